@@ sv/orsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package orsp_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int DELAY_W  = 17;
    localparam int SONG_W   = 32;
    localparam int PAIRS_W  = SONG_W + 1;
    localparam int IDX_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MAP_DEPTH_DEFAULT = 128;

    // Configuration register reset values
    localparam logic [BYTE_W-1:0] SHORT_CODE_RESET = 8'd0;
    localparam logic [BYTE_W-1:0] LONG_CODE_RESET  = 8'd1;
    localparam logic [SONG_W-1:0] SONG_PAIRS_RESET = 32'd0;

    // Chip registers whose writes are dropped (timer/control range)
    localparam logic [BYTE_W-1:0] SUPPRESS_LO = 8'd2;
    localparam logic [BYTE_W-1:0] SUPPRESS_HI = 8'd4;

    // Long delays count in units of 256 ticks
    localparam int LONG_SHIFT = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_CODE = 2'd0,
        CFG_LONG_CODE  = 2'd1,
        CFG_SONG_PAIRS = 2'd2
    } cfg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_REWIND = 2'd1,
        OP_PAIR   = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK      = 3'd0,
        KIND_WRITE    = 3'd1,
        KIND_DELAY    = 3'd2,
        KIND_SUPPRESS = 3'd3,
        KIND_END      = 3'd4,
        KIND_BUSY     = 3'd5
    } kind_t;

    // Classified item handed from front to back
    typedef struct packed {
        op_t                op;
        logic               is_delay;
        logic [DELAY_W-1:0] delay_load;
        logic               bank;
        logic [IDX_W-1:0]   map_idx;
        logic [BYTE_W-1:0]  value;
    } item_t;

endpackage

`default_nettype wire

@@ sv/orsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface orsp_in_if;
    import orsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] code_byte;
    logic [BYTE_W-1:0] value_byte;

    modport source (output valid, output operation, output code_byte,
                    output value_byte, input ready);
    modport sink   (input valid, input operation, input code_byte,
                    input value_byte, output ready);
endinterface

interface orsp_out_if;
    import orsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic               bank;
    logic [BYTE_W-1:0]  chip_register;
    logic [BYTE_W-1:0]  write_value;
    logic [DELAY_W-1:0] delay_left;
    logic               ready_res;

    modport source (output valid, output kind, output bank, output chip_register,
                    output write_value, output delay_left, output ready_res,
                    input ready);
    modport sink   (input valid, input kind, input bank, input chip_register,
                    input write_value, input delay_left, input ready_res,
                    output ready);
endinterface

`default_nettype wire

@@ sv/orsp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module orsp_front (
    orsp_in_if.sink                    in_ch,
    input  wire logic [orsp_pkg::BYTE_W-1:0] short_code,
    input  wire logic [orsp_pkg::BYTE_W-1:0] long_code,
    output orsp_pkg::item_t            push_item,
    output logic                       push_valid,
    input  wire logic                  queue_full
);
    import orsp_pkg::*;

    logic [DELAY_W-1:0] val_plus1;
    logic               is_short;
    logic               is_long;

    assign in_ch.ready = !queue_full;
    assign push_valid  = in_ch.valid;

    // Short code wins when both codes match
    assign is_short  = (in_ch.code_byte == short_code);
    assign is_long   = (in_ch.code_byte == long_code);
    assign val_plus1 = DELAY_W'(in_ch.value_byte) + DELAY_W'(1);

    always_comb
    begin
        push_item.op         = op_t'(in_ch.operation);
        push_item.is_delay   = is_short || is_long;
        push_item.delay_load = is_short ? val_plus1 : (val_plus1 << LONG_SHIFT);
        push_item.bank       = in_ch.code_byte[BYTE_W-1];
        push_item.map_idx    = in_ch.code_byte[IDX_W-1:0];
        push_item.value      = in_ch.value_byte;
    end

endmodule

`default_nettype wire

@@ sv/orsp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module orsp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    input  orsp_pkg::item_t      push_item,
    output logic                 full,
    output logic                 pop_valid,
    output orsp_pkg::item_t      pop_item,
    input  wire logic            pop_ready
);
    import orsp_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign push      = push_valid && !full;
    assign pop       = pop_ready && pop_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/orsp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module orsp_back #(
    parameter int MAP_DEPTH = orsp_pkg::MAP_DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_valid,
    input  orsp_pkg::item_t                  q_item,
    output logic                             q_ready,
    input  wire logic [orsp_pkg::SONG_W-1:0] song_pairs,
    orsp_out_if.source                       out_ch
);
    import orsp_pkg::*;

    localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    logic [BYTE_W-1:0]  map_mem [MAP_DEPTH];
    logic [BYTE_W-1:0]  rdata_reg;

    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [PAIRS_W-1:0] pair_reg, pair_next;
    logic [PAIRS_W-1:0] pair_inc;

    logic               res_valid_reg, res_valid_next;
    kind_t              res_kind_reg, kind_c;
    logic               res_lookup_reg, lookup_c;
    logic               res_ok_reg;
    logic               res_bank_reg;
    logic [BYTE_W-1:0]  res_value_reg;
    logic [DELAY_W-1:0] res_delay_reg;

    logic               adv;
    logic               idx_ok;
    logic [AW-1:0]      addr;
    logic               mem_we;
    logic               suppress;

    assign q_ready = !res_valid_reg || out_ch.ready;
    assign adv     = q_valid && q_ready;

    assign idx_ok = ({1'b0, q_item.map_idx} < 8'(MAP_DEPTH));
    assign addr   = idx_ok ? q_item.map_idx[AW-1:0] : '0;

    // Count saturates at all ones
    assign pair_inc = (&pair_reg) ? pair_reg : pair_reg + PAIRS_W'(1);

    always_comb
    begin
        delay_next = delay_reg;
        pair_next  = pair_reg;
        kind_c     = KIND_ACK;
        lookup_c   = 1'b0;
        mem_we     = 1'b0;
        if (adv)
        begin
            case (q_item.op)
                OP_LOAD:
                begin
                    mem_we = idx_ok;
                end
                OP_REWIND:
                begin
                    delay_next = '0;
                    pair_next  = '0;
                end
                OP_TICK:
                begin
                    if (delay_reg != '0)
                    begin
                        delay_next = delay_reg - DELAY_W'(1);
                    end
                end
                OP_PAIR:
                begin
                    if (delay_reg != '0)
                    begin
                        kind_c = KIND_BUSY;
                    end
                    else
                    begin
                        pair_next = pair_inc;
                        if (pair_inc > {1'b0, song_pairs})
                        begin
                            kind_c = KIND_END;
                        end
                        else if (q_item.is_delay)
                        begin
                            delay_next = q_item.delay_load;
                            kind_c     = KIND_DELAY;
                        end
                        else
                        begin
                            // final write/suppress decided once map data is back
                            kind_c   = KIND_WRITE;
                            lookup_c = 1'b1;
                        end
                    end
                end
                default:
                begin
                    kind_c = KIND_ACK;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (adv)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= '0;
            pair_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            delay_reg     <= delay_next;
            pair_reg      <= pair_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_kind_reg   <= kind_c;
            res_lookup_reg <= lookup_c;
            res_ok_reg     <= idx_ok;
            res_bank_reg   <= q_item.bank;
            res_value_reg  <= q_item.value;
            res_delay_reg  <= delay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[addr] <= q_item.value;
        end
        if (adv)
        begin
            rdata_reg <= map_mem[addr];
        end
    end

    // Out-of-range index reads as chip register 0
    assign out_ch.chip_register = (res_lookup_reg && res_ok_reg) ? rdata_reg : '0;
    assign suppress = (out_ch.chip_register >= SUPPRESS_LO)
                   && (out_ch.chip_register <= SUPPRESS_HI);

    assign out_ch.valid       = res_valid_reg;
    assign out_ch.kind        = res_lookup_reg ? (suppress ? KIND_SUPPRESS : KIND_WRITE)
                                               : res_kind_reg;
    assign out_ch.bank        = res_lookup_reg ? res_bank_reg : 1'b0;
    assign out_ch.write_value = res_lookup_reg ? res_value_reg : '0;
    assign out_ch.delay_left  = res_delay_reg;
    assign out_ch.ready_res   = (res_delay_reg == '0);

endmodule

`default_nettype wire

@@ sv/opl_register_stream_player.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Register-stream player for a recorded sound-chip song. Each input beat is
// a map load, a rewind, a (code, value) pair or a 1 kHz tick, and each gives
// exactly one result beat. Ticks count the pending delay down; pairs are
// refused (busy) while it is nonzero, otherwise they count toward song_pairs
// and either set a delay (short: value+1, long: (value+1)*256), report end
// of song, or turn into a chip register write via the code map (bank from
// code bit 7; chip registers 2..4 come out as suppressed writes). The block
// takes one beat per clock while its queue is not full. An accepted beat
// is registered in the two-entry queue behind the decode front, then in
// the execute stage, whose map read is registered. Throughput is set by the
// execute stage, which retires one beat per cycle when the output is taken.
// Config writes are only legal while idle. Map entries read before they are
// loaded return undefined register numbers.
module opl_register_stream_player #(
    parameter int MAP_DEPTH = orsp_pkg::MAP_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [orsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [orsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    orsp_in_if.sink                               in_ch,
    orsp_out_if.source                            out_ch
);
    import orsp_pkg::*;

    logic [BYTE_W-1:0] short_code_reg;
    logic [BYTE_W-1:0] long_code_reg;
    logic [SONG_W-1:0] song_pairs_reg;

    item_t push_item;
    item_t pop_item;
    logic  push_valid;
    logic  queue_full;
    logic  pop_valid;
    logic  pop_ready;

    // Config registers; index 3 is unmapped and ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_code_reg <= SHORT_CODE_RESET;
            long_code_reg  <= LONG_CODE_RESET;
            song_pairs_reg <= SONG_PAIRS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SHORT_CODE: short_code_reg <= cfg_data[BYTE_W-1:0];
                CFG_LONG_CODE:  long_code_reg  <= cfg_data[BYTE_W-1:0];
                CFG_SONG_PAIRS: song_pairs_reg <= cfg_data[SONG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Front: decode and classify each beat
    orsp_front u_front (
        .in_ch      (in_ch),
        .short_code (short_code_reg),
        .long_code  (long_code_reg),
        .push_item  (push_item),
        .push_valid (push_valid),
        .queue_full (queue_full)
    );

    // Decoupling queue between decode and execute
    orsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // Back: delay/pair state, code map, result register
    orsp_back #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_item     (pop_item),
        .q_ready    (pop_ready),
        .song_pairs (song_pairs_reg),
        .out_ch     (out_ch)
    );

    // A refused pair never leaves the delay at zero
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.kind == KIND_BUSY) |-> !out_ch.ready_res)
        else $error("busy result with zero delay");

    // A delay set always leaves a nonzero delay
    a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.kind == KIND_DELAY) |-> (out_ch.delay_left != '0))
        else $error("delay set result with zero delay");

    // Register writes only pass while no delay is pending
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && ((out_ch.kind == KIND_WRITE) || (out_ch.kind == KIND_SUPPRESS))
        |-> out_ch.ready_res)
        else $error("register write while delay pending");

endmodule

`default_nettype wire

@@ verif/player_scoreboard.sv @@
`timescale 1ns / 1ps

package player_check_pkg;
    import orsp_pkg::*;

    typedef struct packed {
        kind_t              kind;
        logic               bank;
        logic [BYTE_W-1:0]  chip_register;
        logic [BYTE_W-1:0]  write_value;
        logic [DELAY_W-1:0] delay_left;
        logic               ready_res;
    } player_result_t;

    localparam int REPORT_LIMIT = 10;

    class player_scoreboard;
        logic [BYTE_W-1:0]  short_code;
        logic [BYTE_W-1:0]  long_code;
        logic [SONG_W-1:0]  song_len;
        logic [DELAY_W-1:0] delay_ticks;
        logic [PAIRS_W-1:0] pairs_played;
        logic [BYTE_W-1:0]  chip_map [MAP_DEPTH_DEFAULT];
        player_result_t     expected_q [$];
        int                 mismatches;

        function new();
            short_code   = SHORT_CODE_RESET;
            long_code    = LONG_CODE_RESET;
            song_len     = SONG_PAIRS_RESET;
            delay_ticks  = '0;
            pairs_played = '0;
            mismatches   = 0;
            foreach (chip_map[i])
                chip_map[i] = '0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SHORT_CODE: short_code = data[BYTE_W-1:0];
                CFG_LONG_CODE:  long_code  = data[BYTE_W-1:0];
                CFG_SONG_PAIRS: song_len   = data[SONG_W-1:0];
                default: ;
            endcase
        endfunction

        // pair counter saturates at all ones
        function logic [PAIRS_W-1:0] next_pair_count();
            return (&pairs_played) ? pairs_played : pairs_played + PAIRS_W'(1);
        endfunction

        // true when a pair with this code would look up the code map now
        function bit reads_map(logic [BYTE_W-1:0] code);
            return delay_ticks == '0 && next_pair_count() <= {1'b0, song_len}
                && code != short_code && code != long_code;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_beat(op_t op, logic [BYTE_W-1:0] code, logic [BYTE_W-1:0] value);
            player_result_t r;
            r = '0;
            r.kind = KIND_ACK;
            case (op)
                OP_LOAD:   chip_map[code[IDX_W-1:0]] = value;
                OP_REWIND:
                begin
                    delay_ticks  = '0;
                    pairs_played = '0;
                end
                OP_TICK:   if (delay_ticks != '0) delay_ticks = delay_ticks - DELAY_W'(1);
                OP_PAIR:
                begin
                    if (delay_ticks != '0)
                        r.kind = KIND_BUSY;
                    else
                    begin
                        pairs_played = next_pair_count();
                        if (pairs_played > {1'b0, song_len})
                            r.kind = KIND_END;
                        else if (code == short_code)
                        begin
                            delay_ticks = DELAY_W'(value) + DELAY_W'(1);
                            r.kind = KIND_DELAY;
                        end
                        else if (code == long_code)
                        begin
                            delay_ticks = (DELAY_W'(value) + DELAY_W'(1)) << LONG_SHIFT;
                            r.kind = KIND_DELAY;
                        end
                        else
                        begin
                            r.bank          = code[BYTE_W-1];
                            r.chip_register = chip_map[code[IDX_W-1:0]];
                            r.write_value   = value;
                            r.kind = (r.chip_register >= SUPPRESS_LO &&
                                      r.chip_register <= SUPPRESS_HI) ?
                                     KIND_SUPPRESS : KIND_WRITE;
                        end
                    end
                end
                default: ;
            endcase
            r.delay_left = delay_ticks;
            r.ready_res  = (delay_ticks == '0);
            expected_q.push_back(r);
        endfunction

        function void check_beat(player_result_t got);
            player_result_t want;
            bit             bad;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result beat kind=%0d reg=%02h",
                             $realtime, got.kind, got.chip_register);
                return;
            end
            want = expected_q.pop_front();
            bad  = (got.kind !== want.kind) || (got.bank !== want.bank)
                || (got.chip_register !== want.chip_register)
                || (got.write_value !== want.write_value)
                || (got.delay_left !== want.delay_left)
                || (got.ready_res !== want.ready_res);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: result differs: ",
                              "exp kind=%0d bank=%0d reg=%02h val=%02h dly=%0d rdy=%0d, ",
                              "got kind=%0d bank=%0d reg=%02h val=%02h dly=%0d rdy=%0d"},
                             $realtime, want.kind, want.bank, want.chip_register,
                             want.write_value, want.delay_left, want.ready_res,
                             got.kind, got.bank, got.chip_register,
                             got.write_value, got.delay_left, got.ready_res);
            end
        endfunction
    endclass

endpackage

@@ verif/tb.sv @@
`timescale 1ns / 1ps

// Bench for the register stream player. Beats go in one at a time; each
// accepted beat is run through the scoreboard's own copy of the player,
// which queues the single result beat it should produce. Result beats are
// compared in order, field by field.
module tb;
    import orsp_pkg::*;
    import player_check_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    localparam int QUIET_LIMIT   = 20000;   // cycles with no beat on either side
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int PHASE_BEATS   = 455;
    localparam int DRAIN_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    orsp_in_if  in_ch ();
    orsp_out_if out_ch ();

    player_scoreboard sb;
    idle_mode_t       idle_mode;
    int               hold_len;
    int               quiet_cycles;
    bit               map_loaded [MAP_DEPTH_DEFAULT];
    int               loaded_idx [$];
    player_result_t   got;

    always #2 clk = ~clk;

    opl_register_stream_player u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Offer one beat, with a random gap ahead of it in the sender idle modes.
    // Entered and left in the time step of a rising edge. Acceptance is seen
    // at the falling edge, where every signal has settled for the next rise.
    task automatic send_beat(op_t op, logic [BYTE_W-1:0] code, logic [BYTE_W-1:0] value);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 86 : (idle_mode == IDLE_BOTH) ? 16 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.code_byte  <= code;
        in_ch.value_byte <= value;
        do
            @(negedge clk);
        while (!in_ch.ready);
        sb.note_beat(op, code, value);
        if (op == OP_LOAD && !map_loaded[code[IDX_W-1:0]])
        begin
            map_loaded[code[IDX_W-1:0]] = 1'b1;
            loaded_idx.push_back(int'(code[IDX_W-1:0]));
        end
        @(posedge clk);
    endtask

    // Stop sending and wait until every queued result has come back.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three registers back to back while the player is idle.
    // cfg_we stays high across the burst and drops once at the end.
    task automatic write_config(logic [BYTE_W-1:0] short_c, logic [BYTE_W-1:0] long_c,
                                logic [SONG_W-1:0] song);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SHORT_CODE;
        cfg_data  <= CFG_DATA_W'(short_c);
        @(posedge clk);
        cfg_index <= CFG_LONG_CODE;
        cfg_data  <= CFG_DATA_W'(long_c);
        @(posedge clk);
        cfg_index <= CFG_SONG_PAIRS;
        cfg_data  <= CFG_DATA_W'(song);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(CFG_SHORT_CODE, CFG_DATA_W'(short_c));
        sb.set_register(CFG_LONG_CODE, CFG_DATA_W'(long_c));
        sb.set_register(CFG_SONG_PAIRS, CFG_DATA_W'(song));
    endtask

    // Random beat shaped like a real song: while a delay runs, short delays
    // are mostly ticked out and long ones mostly rewound; otherwise mostly
    // pairs, some of them delay codes, short ones mostly with small values.
    task automatic random_beat();
        op_t             op;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] value;
        int              r;
        code  = BYTE_W'($urandom);
        value = BYTE_W'($urandom);
        r     = $urandom_range(0, 99);
        if (sb.delay_ticks != '0)
        begin
            if (sb.delay_ticks <= 12)
                op = (r < 80) ? OP_TICK : OP_PAIR;
            else
                op = (r < 50) ? OP_REWIND : (r < 75) ? OP_TICK : OP_PAIR;
        end
        else
        begin
            if (r < 8)
                op = OP_LOAD;
            else if (r < 14)
                op = OP_REWIND;
            else if (r < 22)
                op = OP_TICK;
            else
                op = OP_PAIR;
            if (op == OP_PAIR)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    code = sb.short_code;
                    if ($urandom_range(0, 3) != 0)
                        value = BYTE_W'($urandom_range(0, 7));
                end
                else if (r < 18)
                    code = sb.long_code;
            end
        end
        // never look up a map entry that was not loaded yet
        if (op == OP_PAIR && sb.reads_map(code) && !map_loaded[code[IDX_W-1:0]])
            code = {code[BYTE_W-1],
                    IDX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)])};
        send_beat(op, code, value);
    endtask

    // Receiver: random stalls in its idle modes, plus a long hold-off on
    // request, counted here so the sender keeps pushing and the player backs up.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                hold_left = hold_len;
                hold_len  = 0;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (idle_mode == IDLE_RECEIVER)
                out_ch.ready <= ($urandom_range(0, 99) >= 86);
            else if (idle_mode == IDLE_BOTH)
                out_ch.ready <= ($urandom_range(0, 99) >= 16);
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Result check and watchdog, both on settled values at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.kind          = kind_t'(out_ch.kind);
            got.bank          = out_ch.bank;
            got.chip_register = out_ch.chip_register;
            got.write_value   = out_ch.write_value;
            got.delay_left    = out_ch.delay_left;
            got.ready_res     = out_ch.ready_res;
            sb.check_beat(got);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        sb           = new();
        idle_mode    = IDLE_NONE;
        hold_len     = 0;
        quiet_cycles = 0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_SHORT_CODE;
        cfg_data         <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.operation  <= OP_LOAD;
        in_ch.code_byte  <= '0;
        in_ch.value_byte <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed. Reset settings: song length 0, so the first pair ends it.
        send_beat(OP_PAIR, 8'h05, 8'h33);
        // map loads; bit 7 of the index is ignored, values span 0..ff
        send_beat(OP_LOAD, 8'h00, 8'h20);
        send_beat(OP_LOAD, 8'hFF, 8'hFF);
        send_beat(OP_LOAD, 8'h05, 8'h02);
        send_beat(OP_LOAD, 8'h86, 8'h03);
        send_beat(OP_LOAD, 8'h07, 8'h04);
        send_beat(OP_LOAD, 8'h08, 8'h01);
        send_beat(OP_LOAD, 8'h09, 8'h05);
        send_beat(OP_LOAD, 8'h0A, 8'h00);

        write_config(8'h00, 8'hFF, 32'hFFFF_FFFF);
        send_beat(OP_REWIND, 8'hAA, 8'h55);
        // writes on both banks, edges of the suppressed range 2..4
        send_beat(OP_PAIR, 8'h80, 8'hFF);
        send_beat(OP_PAIR, 8'h7F, 8'h00);
        send_beat(OP_PAIR, 8'h05, 8'h5A);
        send_beat(OP_PAIR, 8'h86, 8'hA5);
        send_beat(OP_PAIR, 8'h07, 8'h0F);
        send_beat(OP_PAIR, 8'h08, 8'hF0);
        send_beat(OP_PAIR, 8'h89, 8'h3C);
        send_beat(OP_PAIR, 8'h0A, 8'h81);
        // shortest delay, tick it out, then tick at zero
        send_beat(OP_PAIR, 8'h00, 8'h00);
        send_beat(OP_TICK, 8'h00, 8'h00);
        send_beat(OP_TICK, 8'hFF, 8'hFF);
        // longest delay (65536), refused pair while busy, one tick, rewind
        send_beat(OP_PAIR, 8'hFF, 8'hFF);
        send_beat(OP_PAIR, 8'h8A, 8'h11);
        send_beat(OP_TICK, 8'h12, 8'h34);
        send_beat(OP_REWIND, 8'h00, 8'h00);

        // Full speed, endless song; one long receiver hold-off up front.
        write_config(8'h11, 8'h22, 32'hFFFF_FFFF);
        idle_mode = IDLE_NONE;
        hold_len  = HOLD_CYCLES;
        repeat (PHASE_BEATS) random_beat();

        // Sender mostly idle, short song so end-of-song shows up often.
        write_config(8'hFF, 8'h00, 32'd60);
        idle_mode = IDLE_SENDER;
        repeat (PHASE_BEATS) random_beat();

        // Receiver mostly stalled; equal delay codes, short wins.
        write_config(8'h40, 8'h40, 32'd9);
        idle_mode = IDLE_RECEIVER;
        repeat (PHASE_BEATS) random_beat();

        // Light idling on both sides, with a full drain halfway through.
        write_config(8'h00, 8'h80, 32'h7FFF_FFFF);
        idle_mode = IDLE_BOTH;
        repeat (PHASE_BEATS / 2) random_beat();
        wait_idle();
        repeat (PHASE_BEATS - PHASE_BEATS / 2) random_beat();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/orsp_pkg.sv
sv/orsp_if.sv
sv/orsp_front.sv
sv/orsp_queue.sv
sv/orsp_back.sv
sv/opl_register_stream_player.sv
verif/player_scoreboard.sv
verif/tb.sv
